// ===== hw/rtl/mmrsc_pkg.sv =====
// Package: types, constants and helpers for the min/max reject sample combiner.
package mmrsc_pkg;

    localparam int MAX_SAMPLES_DEF = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REJECT_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_REJ     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_REJ    = 2'd3;

    typedef struct packed {
        logic signed [31:0] sci_sample;
        logic signed [31:0] err_sample;
        logic signed [31:0] integ_this;
        logic signed [31:0] integ_next;
        logic        [23:0] scale_factor;
        logic signed [31:0] zero_offset;
        logic        [15:0] quality_this;
        logic        [15:0] quality_next;
        logic               last_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] mean_sci;
        logic        [31:0] combined_err;
        logic signed [31:0] mean_time;
        logic        [5:0]  used_count;
        logic               no_data;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_S, ST_MUL_E, ST_MUL_T, ST_STORE,
        ST_RCNT_H, ST_RCNT_L,
        ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN, ST_SHIFT_RD, ST_SHIFT,
        ST_SUM_RD, ST_SUM, ST_SQRT, ST_DIV_S, ST_DIV_E, ST_DIV_T, ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

endpackage

// ===== hw/rtl/mmrsc_div.sv =====
// Shared radix-2 unsigned divider used for reject counts and means.
module mmrsc_div
    import mmrsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [71:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [71:0] quotient
);
    logic [71:0] q_reg, q_next;
    logic [7:0]  rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[6:0], q_reg[71]};
        done = 1'b0;
        if (start)
        begin
            q_next = dividend;
            rem_next = '0;
            cnt_next = 7'd72;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                q_next = {q_reg[70:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[70:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
        else
            done = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    assign quotient = q_reg;
endmodule

// ===== hw/rtl/mmrsc_sqrt.sv =====
// Bit-serial 64-bit integer square root.
module mmrsc_sqrt
    import mmrsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] n_reg, n_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [63:0] rb;

    always_comb
    begin
        n_next = n_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        rb = r_reg + bit_reg;
        done = 1'b0;
        if (start)
        begin
            n_next = radicand;
            r_next = '0;
            bit_next = 64'd1 << 62;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= rb)
            begin
                n_next = n_reg - rb;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
                r_next = r_reg >> 1;
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
                busy_next = 1'b0;
        end
        else
            done = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
    end

    assign root = r_reg[31:0];
endmodule

// ===== hw/rtl/minmax_reject_sample_combiner.sv =====
// Top level: sample store, rejection sequencer and output register.
//  channel | dir | handshake       | payload
//  in      | in  | in_valid/ready  | in_beat_t
//  out     | out | out_valid/ready | out_beat_t
//  cfg     | in  | cfg_we          | cfg_idx, cfg_data
// A kept sample passes three multiply states and a store; a dropped one goes
// back to idle. A last one adds two 72-step divides for reject counts, a scan and
// shift pass per removal, a sum pass, a 32-step root, three more 72-step divides.
// Ready is low while busy; a finished beat waits in the output register and
// holds the sequencer only while the previous beat is still unread.
// No clearing pass after reset.
module minmax_reject_sample_combiner
    import mmrsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [127:0] mem [MAX_SAMPLES];
    logic [127:0] rd_reg;

    logic [15:0] mask_reg;
    logic [5:0]  nsky_reg, nlow_reg, nhigh_reg;

    state_t state_reg, state_next;
    in_beat_t ib_reg, ib_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] k_reg, k_next;
    logic [AW-1:0] best_reg, best_next;
    logic signed [31:0] bval_reg, bval_next;
    logic [6:0] nh_reg, nh_next, nl_reg, nl_next;
    logic high_reg, high_next;
    logic signed [31:0] s_reg, s_next, t_reg, t_next;
    logic [63:0] e2_reg, e2_next;
    logic signed [39:0] ssum_reg, ssum_next, tsum_reg, tsum_next;
    logic [63:0] esum_reg, esum_next;
    logic [31:0] root_reg, root_next;
    logic signed [31:0] ms_reg, ms_next, mt_reg, mt_next;
    logic [31:0] me_reg, me_next;
    logic ov_reg, ov_next;
    out_beat_t ob_reg, ob_next;

    logic signed [65:0] mul_a;
    logic [23:0] mul_b;
    logic signed [65:0] prod, prod_sh;
    logic signed [31:0] mul_sat;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [127:0] wdata;

    logic dv_start, dv_done, sq_start, sq_done;
    logic [71:0] dv_a, dv_q;
    logic [6:0] dv_b;
    logic [31:0] sq_root;
    logic signed [31:0] rd_sci, rd_time;
    logic [63:0] rd_e2;
    logic [64:0] esum_add;
    logic better;
    logic [39:0] abs_s, abs_t;
    logic [6:0] dv_cnt;

    mmrsc_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
                     .divisor(dv_b), .done(dv_done), .quotient(dv_q));
    mmrsc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(esum_reg),
                       .done(sq_done), .root(sq_root));

    assign prod = mul_a * $signed({42'd0, mul_b});
    assign prod_sh = prod >>> 16;
    assign mul_sat = sat32(prod_sh);

    assign rd_sci = rd_reg[127:96];
    assign rd_e2 = rd_reg[95:32];
    assign rd_time = rd_reg[31:0];
    assign esum_add = {1'b0, esum_reg} + {1'b0, rd_e2};
    assign better = high_reg ? (rd_sci > bval_reg) : (rd_sci < bval_reg);
    assign abs_s = ssum_reg[39] ? -ssum_reg : ssum_reg;
    assign abs_t = tsum_reg[39] ? -tsum_reg : tsum_reg;
    // reject counts of 128 and more act like 127: the store never holds that many
    assign dv_cnt = (dv_q[71:7] != '0) ? 7'h7f : dv_q[6:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        ib_next = ib_reg;
        kept_next = kept_reg;
        k_next = k_reg;
        best_next = best_reg;
        bval_next = bval_reg;
        nh_next = nh_reg;
        nl_next = nl_reg;
        high_next = high_reg;
        s_next = s_reg;
        t_next = t_reg;
        e2_next = e2_reg;
        ssum_next = ssum_reg;
        tsum_next = tsum_reg;
        esum_next = esum_reg;
        root_next = root_reg;
        ms_next = ms_reg;
        me_next = me_reg;
        mt_next = mt_reg;
        ov_next = ov_reg;
        ob_next = ob_reg;
        in_ready = 1'b0;
        we = 1'b0;
        waddr = kept_reg[AW-1:0];
        wdata = {s_reg, e2_reg, t_reg};
        raddr = k_reg[AW-1:0];
        dv_start = 1'b0;
        dv_a = '0;
        dv_b = {1'b0, nsky_reg};
        sq_start = 1'b0;
        mul_a = 66'(ib_reg.sci_sample);
        mul_b = ib_reg.scale_factor;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ib_next = in_data;
                    if (((in_data.quality_this | in_data.quality_next) & mask_reg) == '0
                        && kept_reg < CW'(MAX_SAMPLES))
                        state_next = ST_MUL_S;
                    else if (in_data.last_sample)
                        state_next = ST_RCNT_H;
                end
            end
            ST_MUL_S:
            begin
                s_next = sat32(66'(mul_sat) - 66'(ib_reg.zero_offset));
                state_next = ST_MUL_E;
            end
            ST_MUL_E:
            begin
                mul_a = 66'(ib_reg.err_sample);
                t_next = sat32(66'(mul_sat) - 66'(ib_reg.zero_offset));
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                mul_a = 66'(ib_reg.integ_this) - 66'(ib_reg.integ_next);
                e2_next = (t_reg[31] ? 64'(-33'(t_reg)) : 64'(t_reg))
                        * (t_reg[31] ? 64'(-33'(t_reg)) : 64'(t_reg));
                t_next = mul_sat;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                we = 1'b1;
                kept_next = kept_reg + CW'(1);
                state_next = ib_reg.last_sample ? ST_RCNT_H : ST_IDLE;
            end
            ST_RCNT_H:
            begin
                if (nsky_reg == '0)
                begin
                    nh_next = '0;
                    nl_next = '0;
                    high_next = 1'b1;
                    state_next = ST_SCAN_INIT;
                end
                else
                begin
                    dv_start = k_reg != '1;
                    dv_a = {60'd0, 12'(nhigh_reg) * 12'(kept_reg)};
                    if (k_reg == '1 && dv_done)
                    begin
                        nh_next = dv_cnt;
                        k_next = '0;
                        state_next = ST_RCNT_L;
                    end
                    else
                        k_next = '1;
                end
            end
            ST_RCNT_L:
            begin
                dv_start = k_reg != '1;
                dv_a = {60'd0, 12'(nlow_reg) * 12'(kept_reg)};
                if (k_reg == '1 && dv_done)
                begin
                    nl_next = dv_cnt;
                    high_next = 1'b1;
                    state_next = ST_SCAN_INIT;
                end
                else
                    k_next = '1;
            end
            ST_SCAN_INIT:
            begin
                k_next = '0;
                if (high_reg && (nh_reg == '0 || kept_reg <= CW'(1)))
                    high_next = 1'b0;
                else if (!high_reg && (nl_reg == '0 || kept_reg <= CW'(1)))
                begin
                    ssum_next = '0;
                    tsum_next = '0;
                    esum_next = '0;
                    state_next = ST_SUM_RD;
                end
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                k_next = k_reg + CW'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (k_reg == CW'(1) || better)
                begin
                    best_next = AW'(k_reg - CW'(1));
                    bval_next = rd_sci;
                end
                if (k_reg == kept_reg)
                begin
                    k_next = CW'(best_next) + CW'(1);
                    state_next = ST_SHIFT_RD;
                end
                else
                    k_next = k_reg + CW'(1);
            end
            ST_SHIFT_RD:
            begin
                if (k_reg >= kept_reg)
                begin
                    kept_next = kept_reg - CW'(1);
                    if (high_reg)
                        nh_next = nh_reg - 7'd1;
                    else
                        nl_next = nl_reg - 7'd1;
                    state_next = ST_SCAN_INIT;
                end
                else
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                we = 1'b1;
                waddr = AW'(k_reg - CW'(1));
                wdata = rd_reg;
                k_next = k_reg + CW'(1);
                state_next = ST_SHIFT_RD;
            end
            ST_SUM_RD:
            begin
                if (k_reg >= kept_reg)
                begin
                    sq_start = 1'b1;
                    state_next = ST_SQRT;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                ssum_next = ssum_reg + 40'(rd_sci);
                tsum_next = tsum_reg + 40'(rd_time);
                esum_next = esum_add[64] ? '1 : esum_add[63:0];
                state_next = ST_SUM_RD;
            end
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    root_next = sq_root;
                    k_next = '0;
                    state_next = kept_reg == '0 ? ST_OUT : ST_DIV_S;
                end
            end
            ST_DIV_S, ST_DIV_E, ST_DIV_T:
            begin
                dv_b = 7'(kept_reg);
                dv_a = state_reg == ST_DIV_S ? 72'(abs_s)
                     : state_reg == ST_DIV_E ? 72'(root_reg) : 72'(abs_t);
                dv_start = k_reg != '1;
                if (k_reg == '1 && dv_done)
                begin
                    k_next = '0;
                    case (state_reg)
                        ST_DIV_S:
                        begin
                            ms_next = ssum_reg[39] ? -dv_q[31:0] : dv_q[31:0];
                            state_next = ST_DIV_E;
                        end
                        ST_DIV_E:
                        begin
                            me_next = dv_q[31:0];
                            state_next = ST_DIV_T;
                        end
                        default:
                        begin
                            mt_next = tsum_reg[39] ? -dv_q[31:0] : dv_q[31:0];
                            state_next = ST_OUT;
                        end
                    endcase
                end
                else
                    k_next = '1;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ob_next.no_data = kept_reg == '0;
                    ob_next.used_count = 6'(kept_reg);
                    ob_next.mean_sci = kept_reg == '0 ? '0 : ms_reg;
                    ob_next.combined_err = kept_reg == '0 ? '0 : me_reg;
                    ob_next.mean_time = kept_reg == '0 ? '0 : mt_reg;
                    ov_next = 1'b1;
                    kept_next = '0;
                    k_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kept_reg <= '0;
            k_reg <= '0;
            ov_reg <= 1'b0;
            mask_reg <= '0;
            nsky_reg <= 6'd1;
            nlow_reg <= '0;
            nhigh_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kept_reg <= kept_next;
            k_reg <= k_next;
            ov_reg <= ov_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_REJECT_MASK: mask_reg <= cfg_data;
                    REG_SAMPLES:     nsky_reg <= cfg_data[5:0];
                    REG_LOW_REJ:     nlow_reg <= cfg_data[5:0];
                    REG_HIGH_REJ:    nhigh_reg <= cfg_data[5:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ib_reg <= ib_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        nh_reg <= nh_next;
        nl_reg <= nl_next;
        high_reg <= high_next;
        s_reg <= s_next;
        t_reg <= t_next;
        e2_reg <= e2_next;
        ssum_reg <= ssum_next;
        tsum_reg <= tsum_next;
        esum_reg <= esum_next;
        root_reg <= root_next;
        ms_reg <= ms_next;
        me_reg <= me_next;
        mt_reg <= mt_next;
        ob_reg <= ob_next;
    end

    assign out_valid = ov_reg;
    assign out_data = ob_reg;
endmodule

// ===== hw/rtl/mmrsc_checker.sv =====
// Port-level checker for the combiner, bound to the top level.
module mmrsc_checker
    import mmrsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed while stalled");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid}))
        else $error("handshake signal unknown");
    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_data |-> out_data.used_count == '0
            && out_data.mean_sci == '0 && out_data.combined_err == '0)
        else $error("no-data beat carries values");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.no_data |-> out_data.used_count != '0)
        else $error("zero count without no-data");
endmodule

bind minmax_reject_sample_combiner mmrsc_checker u_mmrsc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
